// ----- hw/rtl/pure_pursuit_steering_unit_macros.svh -----
// Assertion macros shared by the steering unit RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PURE_PURSUIT_STEERING_UNIT_MACROS_SVH
`define PURE_PURSUIT_STEERING_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PPSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pure pursuit steering unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pure pursuit steering unit: assertion failed");

`else

`define PPSU_ASSERT_IMP(lbl, ante, cons)
`define PPSU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/ppsu_pkg.sv -----
package ppsu_pkg;

  // Table size and index widths.
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int FRAC_BITS  = 16;
  localparam int APB_ADDR_W = 5;

  // Shared CORDIC datapath.
  localparam int CORDIC_STEPS = 20;
  localparam int CV_W         = 45;
  localparam logic signed [CV_W-1:0] CORDIC_GAIN = CV_W'(652032874);
  localparam logic signed [CV_W-1:0] NORM_LIM    = CV_W'(64'd1 << 40);
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [32:0] STRAIGHT_LIMIT = 33'd6836;

  // Iterative divide and square root.
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_LOOKAHEAD_GAIN = 3'd0;
  localparam logic [2:0] REG_BASE_LOOKAHEAD = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN     = 3'd2;
  localparam logic [2:0] REG_WHEELBASE      = 3'd3;
  localparam logic [2:0] REG_MAX_LAT_ACCEL  = 3'd4;
  localparam logic [2:0] REG_CRUISE_SPEED   = 3'd5;
  localparam logic [2:0] REG_POINT_COUNT    = 3'd6;

  // Register reset values.
  localparam logic [23:0] RST_LOOKAHEAD_GAIN = 24'd6554;
  localparam logic [30:0] RST_BASE_LOOKAHEAD = 31'd131072;
  localparam logic [23:0] RST_SPEED_GAIN     = 24'd65536;
  localparam logic [30:0] RST_WHEELBASE      = 31'd190054;
  localparam logic [23:0] RST_MAX_LAT_ACCEL  = 24'd131072;
  localparam logic [22:0] RST_CRUISE_SPEED   = 23'd182044;
  localparam logic [10:0] RST_POINT_COUNT    = 11'd100;

  // Control and status between the sequencer and its arithmetic units.
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef struct packed {
    logic start;
    logic sqrt_op;
  } divsqrt_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Arctangent of 2^-i, in units of 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/pure_pursuit_steering_unit.sv -----
// Pure-pursuit steering unit. A word is taken when start is high and busy is low; each
// word gives exactly one result, shown for one cycle with result_strobe high, which the
// receiver must take at once. For load and restart words busy stays low and the result
// (all zeros) appears in the next cycle. A control tick holds busy high while the path
// memory, read one point a cycle into a four-stage distance pipeline, is swept over the
// points in use once for the nearest point (on the first tick after reset or restart,
// otherwise a forward walk) and once more for the lookahead point, and while four passes
// of the shared 20-step CORDIC and, on a curve, a divider and a square root run. The path
// memory needs no clearing pass; reading a slot that was never loaded gives undefined
// results.
`include "pure_pursuit_steering_unit_macros.svh"

module pure_pursuit_steering_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppsu_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind,
  input  logic [ppsu_pkg::IDX_W-1:0]          point_index,
  input  logic signed [31:0]                  point_x,
  input  logic signed [31:0]                  point_y,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic [15:0]                         heading,
  input  logic signed [23:0]                  speed,
  output logic                                result_strobe,
  output logic signed [15:0]                  steer_angle,
  output logic signed [31:0]                  accel,
  output logic [ppsu_pkg::IDX_W-1:0]          target_index,
  output logic                                done_res
);
  import ppsu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_HSTART, S_HEAD, S_MULH, S_REAR, S_LF2, S_NEAR, S_LOOK, S_TSEL, S_TRD,
    S_TVEC, S_ALPHA, S_SINS, S_SIN, S_YMUL, S_YT, S_DSTART, S_DELTA, S_DECIDE,
    S_RMUL, S_RDIVS, S_RDIV, S_PMUL, S_PSUM, S_SQS, S_SQRT, S_ACC, S_FIN
  } state_t;

  // Configuration registers.
  logic [23:0] lookahead_gain, speed_gain, max_lat_accel;
  logic [30:0] base_lookahead, wheelbase;
  logic [22:0] cruise_speed;
  logic [10:0] point_count;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead_gain <= RST_LOOKAHEAD_GAIN;
      base_lookahead <= RST_BASE_LOOKAHEAD;
      speed_gain     <= RST_SPEED_GAIN;
      wheelbase      <= RST_WHEELBASE;
      max_lat_accel  <= RST_MAX_LAT_ACCEL;
      cruise_speed   <= RST_CRUISE_SPEED;
      point_count    <= RST_POINT_COUNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOOKAHEAD_GAIN: lookahead_gain <= pwdata[23:0];
        REG_BASE_LOOKAHEAD: base_lookahead <= pwdata[30:0];
        REG_SPEED_GAIN:     speed_gain     <= pwdata[23:0];
        REG_WHEELBASE:      wheelbase      <= pwdata[30:0];
        REG_MAX_LAT_ACCEL:  max_lat_accel  <= pwdata[23:0];
        REG_CRUISE_SPEED:   cruise_speed   <= pwdata[22:0];
        REG_POINT_COUNT:    point_count    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_LOOKAHEAD_GAIN: prdata = {8'd0, lookahead_gain};
      REG_BASE_LOOKAHEAD: prdata = {1'b0, base_lookahead};
      REG_SPEED_GAIN:     prdata = {8'd0, speed_gain};
      REG_WHEELBASE:      prdata = {1'b0, wheelbase};
      REG_MAX_LAT_ACCEL:  prdata = {8'd0, max_lat_accel};
      REG_CRUISE_SPEED:   prdata = {9'd0, cruise_speed};
      REG_POINT_COUNT:    prdata = {21'd0, point_count};
      default:            prdata = '0;
    endcase
  end

  // Points in use, clamped to the table, and the last index.
  logic [CNT_W-1:0] n_pts;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    if (point_count == '0) begin
      n_pts = CNT_W'(1);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      n_pts = CNT_W'(MAX_POINTS);
    end else begin
      n_pts = point_count;
    end
    last_idx = IDX_W'(n_pts - CNT_W'(1));
  end

  state_t st;
  logic   accept;

  assign busy   = (st != S_IDLE);
  assign accept = start && !busy;

  // Path memory: x in the upper half of a word, y in the lower half.
  logic [63:0]      path_mem [MAX_POINTS];
  logic [63:0]      rd_data;
  logic [IDX_W-1:0] rd_addr, iss_idx, tp_idx;
  logic             iss_active;

  assign rd_addr = iss_active ? iss_idx : tp_idx;

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_LOAD) begin
      path_mem[point_index] <= {point_x, point_y};
    end
    rd_data <= path_mem[rd_addr];
  end

  // Tick state.
  logic signed [31:0] px, py;
  logic [31:0]        yaw32;
  logic signed [23:0] v;
  logic signed [31:0] hc, hs, sin_val;
  logic signed [62:0] prod_hx, prod_hy;
  logic signed [47:0] kv_prod;
  logic signed [33:0] rx, ry;
  logic [31:0]        lf;
  logic [63:0]        lf2;
  logic signed [63:0] yprod;
  logic signed [33:0] ytan;
  logic [31:0]        delta;
  logic [62:0]        rprod, rquo;
  logic [33:0]        ay;
  logic [55:0]        plo;
  logic [54:0]        phi;
  logic [63:0]        psat;
  logic [22:0]        tgt;
  logic signed [49:0] aprod;

  logic [IDX_W-1:0] nearest_index, previous_target, near_ind, look_ind, ind_reg;
  logic             nearest_known, scan_mode, seen;
  logic [63:0]      best;

  // Distance pipeline: memory read, differences, squares, saturating sum.
  logic             v0, v1, v2, v3;
  logic [IDX_W-1:0] idx0, idx1, idx2, idx3;
  logic [31:0]      a1x, a1y;
  logic             ovf1, ovf2;
  logic [63:0]      sq2x, sq2y, d3;
  logic signed [34:0] dx1, dy1;
  logic [34:0]      ax1, ay1;
  logic [64:0]      sum3;
  logic             stream_flush;

  always_comb begin
    dx1  = {rx[33], rx} - {{3{rd_data[63]}}, rd_data[63:32]};
    dy1  = {ry[33], ry} - {{3{rd_data[31]}}, rd_data[31:0]};
    ax1  = dx1[34] ? 35'(-dx1) : 35'(dx1);
    ay1  = dy1[34] ? 35'(-dy1) : 35'(dy1);
    sum3 = {1'b0, sq2x} + {1'b0, sq2y};
  end

  always_ff @(posedge clk) begin
    idx0 <= iss_idx;
    idx1 <= idx0;
    a1x  <= ax1[31:0];
    a1y  <= ay1[31:0];
    ovf1 <= (ax1[34:32] != 3'd0) || (ay1[34:32] != 3'd0);
    idx2 <= idx1;
    sq2x <= a1x * a1x;
    sq2y <= a1y * a1y;
    ovf2 <= ovf1;
    idx3 <= idx2;
    d3   <= (ovf2 || sum3[64]) ? '1 : sum3[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst || stream_flush) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= iss_active;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Search decisions on each distance that leaves the pipeline.
  logic             near_take, near_end, look_end;
  logic [IDX_W-1:0] near_ind_new, walk_start, ind_sel, tp_sel;

  always_comb begin
    if (scan_mode) begin
      near_take = !seen || (d3 < best);
      near_end  = (idx3 == last_idx);
    end else begin
      near_take = !seen || !(best < d3);
      near_end  = (idx3 == last_idx) || (seen && (best < d3));
    end
    near_ind_new = near_take ? idx3 : near_ind;
    look_end     = !(lf2 > d3) || (idx3 == last_idx);
    stream_flush = v3 && (((st == S_NEAR) && near_end) || ((st == S_LOOK) && look_end));
    walk_start   = (nearest_index <= last_idx) ? nearest_index : last_idx;
    ind_sel      = (previous_target >= look_ind) ? previous_target : look_ind;
    tp_sel       = (ind_sel <= last_idx) ? ind_sel : last_idx;
  end

  // Arithmetic units.
  cordic_ctl_t        cordic_ctl;
  unit_stat_t         cordic_stat, ds_stat;
  divsqrt_ctl_t       ds_ctl;
  logic [31:0]        cordic_angle, cordic_aout;
  logic signed [CV_W-1:0] cordic_x, cordic_y;
  logic signed [31:0] cordic_cos, cordic_sin;
  logic [63:0]        ds_dividend, ds_result;
  logic signed [34:0] tdx, tdy;

  always_comb begin
    tdx = {{3{rd_data[63]}}, rd_data[63:32]} - {rx[33], rx};
    tdy = {{3{rd_data[31]}}, rd_data[31:0]} - {ry[33], ry};
    cordic_ctl.start     = (st == S_HSTART) || (st == S_TVEC) || (st == S_SINS) ||
                           (st == S_DSTART);
    cordic_ctl.vectoring = (st == S_TVEC) || (st == S_DSTART);
    cordic_angle         = (st == S_SINS) ? cordic_aout - yaw32 : yaw32;
    if (st == S_TVEC) begin
      cordic_x = CV_W'(tdx);
      cordic_y = CV_W'(tdy);
    end else begin
      cordic_x = $signed({{(CV_W-32){1'b0}}, lf});
      cordic_y = CV_W'(ytan);
    end
    ds_ctl.start   = (st == S_RDIVS) || (st == S_SQS);
    ds_ctl.sqrt_op = (st == S_SQS);
    ds_dividend    = (st == S_SQS) ? psat : {1'b0, rprod};
  end

  ppsu_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cordic_ctl),
    .angle_in  (cordic_angle),
    .vec_x     (cordic_x),
    .vec_y     (cordic_y),
    .stat      (cordic_stat),
    .cos_out   (cordic_cos),
    .sin_out   (cordic_sin),
    .angle_out (cordic_aout)
  );

  ppsu_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ds_ctl),
    .dividend (ds_dividend),
    .divisor  (ay),
    .stat     (ds_stat),
    .result   (ds_result)
  );

  // Combinational helpers for the sequencer.
  logic signed [31:0] kv;
  logic signed [32:0] lf_sum, dsum;
  logic [32:0]        abs_d;
  logic               curve;
  logic [64:0]        psum;
  logic signed [24:0] vdiff;
  logic signed [33:0] acc_sh;

  always_comb begin
    kv     = 32'(kv_prod >>> FRAC_BITS);
    lf_sum = {kv[31], kv} + {2'b00, base_lookahead};
    abs_d  = delta[31] ? 33'(-{delta[31], delta}) : {1'b0, delta};
    curve  = (abs_d >= STRAIGHT_LIMIT) && (ytan != 0);
    psum   = {9'd0, plo} + {1'b0, phi[31:0], 32'd0};
    vdiff  = $signed({2'b00, tgt}) - {v[23], v};
    acc_sh = 34'(aprod >>> FRAC_BITS);
    dsum   = {delta[31], delta} + 33'sd32768;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      result_strobe   <= 1'b0;
      nearest_index   <= '0;
      nearest_known   <= 1'b0;
      previous_target <= '0;
      iss_active      <= 1'b0;
      seen            <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (iss_active) begin
        if (iss_idx == last_idx) begin
          iss_active <= 1'b0;
        end else begin
          iss_idx <= iss_idx + IDX_W'(1);
        end
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_TICK) begin
              px    <= pos_x;
              py    <= pos_y;
              yaw32 <= {heading, 16'd0};
              v     <= speed;
              st    <= S_HSTART;
            end else begin
              if (kind == KIND_RESTART) begin
                nearest_known   <= 1'b0;
                previous_target <= '0;
              end
              steer_angle   <= '0;
              accel         <= '0;
              target_index  <= '0;
              done_res      <= 1'b0;
              result_strobe <= 1'b1;
            end
          end
        end
        S_HSTART: st <= S_HEAD;
        S_HEAD: begin
          if (cordic_stat.done) begin
            hc <= cordic_cos;
            hs <= cordic_sin;
            st <= S_MULH;
          end
        end
        S_MULH: begin
          prod_hx <= $signed({1'b0, wheelbase[30:1]}) * hc;
          prod_hy <= $signed({1'b0, wheelbase[30:1]}) * hs;
          kv_prod <= $signed({1'b0, lookahead_gain}) * v;
          st      <= S_REAR;
        end
        S_REAR: begin
          rx <= {{2{px[31]}}, px} - 34'(prod_hx >>> 30);
          ry <= {{2{py[31]}}, py} - 34'(prod_hy >>> 30);
          lf <= (lf_sum < 33'sd1) ? 32'd1 : lf_sum[31:0];
          st <= S_LF2;
        end
        S_LF2: begin
          lf2        <= lf * lf;
          scan_mode  <= !nearest_known;
          seen       <= 1'b0;
          iss_idx    <= nearest_known ? walk_start : '0;
          iss_active <= 1'b1;
          st         <= S_NEAR;
        end
        S_NEAR: begin
          if (v3) begin
            if (near_take) begin
              best     <= d3;
              near_ind <= idx3;
            end
            seen <= 1'b1;
            if (near_end) begin
              nearest_index <= near_ind_new;
              nearest_known <= 1'b1;
              iss_idx       <= near_ind_new;
              iss_active    <= 1'b1;
              st            <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (v3 && look_end) begin
            look_ind   <= idx3;
            iss_active <= 1'b0;
            st         <= S_TSEL;
          end
        end
        S_TSEL: begin
          ind_reg <= ind_sel;
          tp_idx  <= tp_sel;
          st      <= S_TRD;
        end
        S_TRD:  st <= S_TVEC;
        S_TVEC: st <= S_ALPHA;
        S_ALPHA: begin
          if (cordic_stat.done) begin
            st <= S_SINS;
          end
        end
        S_SINS: st <= S_SIN;
        S_SIN: begin
          if (cordic_stat.done) begin
            sin_val <= cordic_sin;
            st      <= S_YMUL;
          end
        end
        S_YMUL: begin
          yprod <= $signed({1'b0, wheelbase}) * sin_val;
          st    <= S_YT;
        end
        S_YT: begin
          ytan <= 34'(yprod >>> 29);
          st   <= S_DSTART;
        end
        S_DSTART: st <= S_DELTA;
        S_DELTA: begin
          if (cordic_stat.done) begin
            delta <= cordic_aout;
            st    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          tgt <= cruise_speed;
          st  <= curve ? S_RMUL : S_ACC;
        end
        S_RMUL: begin
          rprod <= wheelbase * lf;
          ay    <= ytan[33] ? 34'(-ytan) : 34'(ytan);
          st    <= S_RDIVS;
        end
        S_RDIVS: st <= S_RDIV;
        S_RDIV: begin
          if (ds_stat.done) begin
            rquo <= ds_result[62:0];
            st   <= S_PMUL;
          end
        end
        S_PMUL: begin
          plo <= max_lat_accel * rquo[31:0];
          phi <= max_lat_accel * rquo[62:32];
          st  <= S_PSUM;
        end
        S_PSUM: begin
          psat <= ((phi[54:32] != '0) || psum[64]) ? '1 : psum[63:0];
          st   <= S_SQS;
        end
        S_SQS: st <= S_SQRT;
        S_SQRT: begin
          if (ds_stat.done) begin
            if ({41'd0, cruise_speed} > ds_result) begin
              tgt <= ds_result[22:0];
            end
            st <= S_ACC;
          end
        end
        S_ACC: begin
          aprod <= $signed({1'b0, speed_gain}) * vdiff;
          st    <= S_FIN;
        end
        S_FIN: begin
          if (acc_sh > 34'sh0_7FFF_FFFF) begin
            accel <= 32'sh7FFF_FFFF;
          end else if (acc_sh < -34'sh0_8000_0000) begin
            accel <= 32'sh8000_0000;
          end else begin
            accel <= acc_sh[31:0];
          end
          steer_angle     <= dsum[31:16];
          target_index    <= ind_reg;
          done_res        <= (ind_reg >= last_idx);
          previous_target <= ind_reg;
          result_strobe   <= 1'b1;
          st              <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and its units.
  `PPSU_ASSERT_IMP(a_issue_bound, iss_active, iss_idx <= last_idx)
  `PPSU_ASSERT_IMP(a_cordic_idle, cordic_ctl.start, !cordic_stat.busy)
  `PPSU_ASSERT_IMP(a_done_index, result_strobe && done_res, target_index >= last_idx)
  `PPSU_ASSERT_NXT(a_tick_busy, start && !busy && kind == KIND_TICK, busy)

endmodule

// ----- hw/rtl/ppsu_cordic.sv -----
module ppsu_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  ppsu_pkg::cordic_ctl_t               ctl,
  input  logic [31:0]                         angle_in,
  input  logic signed [ppsu_pkg::CV_W-1:0]    vec_x,
  input  logic signed [ppsu_pkg::CV_W-1:0]    vec_y,
  output ppsu_pkg::unit_stat_t                stat,
  output logic signed [31:0]                  cos_out,
  output logic signed [31:0]                  sin_out,
  output logic [31:0]                         angle_out
);
  import ppsu_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

  cstate_t                st;
  logic signed [CV_W-1:0] x, y;
  logic signed [33:0]     z;
  logic [4:0]             step;
  logic                   vec, flip, done;

  logic signed [CV_W-1:0] xs, ys, xn, yn;
  logic signed [33:0]     zn, atan_z;
  logic                   dpos, norm_go;
  logic [31:0]            a_sum, a_adj;

  // One micro-rotation per cycle; direction from the angle or from the sign of y.
  always_comb begin
    xs      = x >>> step;
    ys      = y >>> step;
    atan_z  = $signed({2'b00, atan_turn(step)});
    dpos    = vec ? (y <= 0) : (z >= 0);
    norm_go = (x < NORM_LIM) && (y < NORM_LIM) && (y > -NORM_LIM);
    if (dpos) begin
      xn = x - ys;
      yn = y + xs;
      zn = z - atan_z;
    end else begin
      xn = x + ys;
      yn = y - xs;
      zn = z + atan_z;
    end
    a_sum = angle_in + QUARTER_TURN;
    a_adj = a_sum[31] ? angle_in - HALF_TURN : angle_in;
  end

  // Sequencer: start, normalise (vectoring only), iterate.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        C_IDLE: begin
          if (ctl.start) begin
            vec  <= ctl.vectoring;
            step <= '0;
            if (ctl.vectoring) begin
              flip <= 1'b0;
              if (vec_x == 0 && vec_y == 0) begin
                angle_out <= '0;
                done      <= 1'b1;
              end else if (vec_x < 0) begin
                x  <= -vec_x;
                y  <= -vec_y;
                z  <= $signed({2'b00, HALF_TURN});
                st <= C_NORM;
              end else begin
                x  <= vec_x;
                y  <= vec_y;
                z  <= '0;
                st <= C_NORM;
              end
            end else begin
              flip <= a_sum[31];
              x    <= CORDIC_GAIN;
              y    <= '0;
              z    <= {{2{a_adj[31]}}, a_adj};
              st   <= C_ITER;
            end
          end
        end
        C_NORM: begin
          if (norm_go) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            st <= C_ITER;
          end
        end
        C_ITER: begin
          x    <= xn;
          y    <= yn;
          z    <= zn;
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STEPS - 1)) begin
            cos_out   <= flip ? -xn[31:0] : xn[31:0];
            sin_out   <= flip ? -yn[31:0] : yn[31:0];
            angle_out <= zn[31:0];
            done      <= 1'b1;
            st        <= C_IDLE;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  assign stat.busy = (st != C_IDLE);
  assign stat.done = done;

endmodule

// ----- hw/rtl/ppsu_divsqrt.sv -----
module ppsu_divsqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  ppsu_pkg::divsqrt_ctl_t ctl,
  input  logic [63:0]            dividend,
  input  logic [33:0]            divisor,
  output ppsu_pkg::unit_stat_t   stat,
  output logic [63:0]            result
);
  import ppsu_pkg::*;

  typedef enum logic [1:0] {Q_IDLE, Q_DIV, Q_SQRT} qstate_t;

  qstate_t     st;
  logic [63:0] work, root, bit_m;
  logic [34:0] rem;
  logic [33:0] dvs;
  logic [5:0]  cnt;
  logic        done;

  logic [34:0] rem_sh;
  logic        div_ge, sq_ge;
  logic [63:0] trial, quo_next, root_next;

  // Restoring divide takes one quotient bit a cycle; the root one result bit a cycle.
  always_comb begin
    rem_sh    = {rem[33:0], work[63]};
    div_ge    = rem_sh >= {1'b0, dvs};
    quo_next  = {work[62:0], div_ge};
    trial     = root + bit_m;
    sq_ge     = work >= trial;
    root_next = sq_ge ? (root >> 1) + bit_m : root >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= Q_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        Q_IDLE: begin
          if (ctl.start) begin
            work <= dividend;
            cnt  <= '0;
            if (ctl.sqrt_op) begin
              root  <= '0;
              bit_m <= 64'h4000_0000_0000_0000;
              st    <= Q_SQRT;
            end else begin
              rem <= '0;
              dvs <= divisor;
              st  <= Q_DIV;
            end
          end
        end
        Q_DIV: begin
          rem  <= div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
          work <= quo_next;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) begin
            result <= quo_next;
            done   <= 1'b1;
            st     <= Q_IDLE;
          end
        end
        Q_SQRT: begin
          if (sq_ge) begin
            work <= work - trial;
          end
          root  <= root_next;
          bit_m <= bit_m >> 2;
          cnt   <= cnt + 6'd1;
          if (cnt == 6'(SQRT_STEPS - 1)) begin
            result <= root_next;
            done   <= 1'b1;
            st     <= Q_IDLE;
          end
        end
        default: st <= Q_IDLE;
      endcase
    end
  end

  assign stat.busy = (st != Q_IDLE);
  assign stat.done = done;

endmodule
